// File: rtl/slg_pkg.sv
`default_nettype none

package slg_pkg;

	localparam int unsigned WORD_W = 32;
	localparam logic [WORD_W-1:0] LCG_MULT = 32'd1664525;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_FILL,
		S_IDX,
		S_RD,
		S_WR
	} slg_state_t;

	typedef struct packed {
		logic ld_seed;
		logic fill;
		logic draw_idx;
		logic draw_rd;
		logic draw_wr;
	} slg_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic out_free;
	} slg_status_t;

endpackage

`default_nettype wire

// File: rtl/slg_datapath.sv
`default_nettype none

module slg_datapath #(
	parameter int unsigned TABLE_SIZE = 97
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	input  wire  [slg_pkg::WORD_W-1:0]    cfg_data,
	input  wire  slg_pkg::slg_cmd_t       cmd,
	output slg_pkg::slg_status_t          st,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [slg_pkg::WORD_W-1:0]    out_data
);
	import slg_pkg::*;

	localparam int unsigned IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int unsigned CW = $clog2(TABLE_SIZE + 1);
	localparam int unsigned PW = WORD_W + CW;
	localparam logic [CW-1:0] TS = CW'(TABLE_SIZE);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] last_q;
	logic [IW-1:0]     fill_q;
	logic [IW-1:0]     idx_q;
	logic [WORD_W-1:0] rd_q;
	logic              rd_vld_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_data_q;
	logic [TABLE_SIZE-1:0] vld_q;
	logic [WORD_W-1:0] mem [TABLE_SIZE];

	logic [WORD_W-1:0] lcg_w;
	logic [PW-1:0]     prod;
	logic [WORD_W-1:0] draw_val;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	assign lcg_w    = word_q * LCG_MULT;
	assign prod     = {{CW{1'b0}}, last_q} * {{WORD_W{1'b0}}, TS};
	assign draw_val = rd_vld_q ? rd_q : '0;

	assign wr_en   = cmd.fill | cmd.draw_wr;
	assign wr_addr = cmd.fill ? fill_q : idx_q;
	assign wr_data = cmd.fill ? lcg_w : word_q;

	assign st.fill_last = (fill_q == LAST_IDX);
	assign st.out_free  = ~out_valid_q | ~out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= 32'd1;
			word_q      <= '0;
			last_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (cfg_valid)
				seed_q <= cfg_data;
			// even seed plus one is the same as setting bit 0
			if (cmd.ld_seed) begin
				word_q <= seed_q | 32'd1;
				fill_q <= '0;
			end
			if (cmd.fill) begin
				word_q <= lcg_w;
				if (st.fill_last)
					last_q <= 32'd1;
				else
					fill_q <= fill_q + 1'b1;
			end
			if (cmd.draw_rd)
				word_q <= lcg_w;
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (cmd.draw_wr) begin
				last_q      <= draw_val;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_idx)
			idx_q <= prod[WORD_W +: IW];
		if (cmd.draw_rd)
			rd_vld_q <= vld_q[idx_q];
		if (cmd.draw_wr)
			out_data_q <= draw_val;
	end

	// shuffle table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[idx_q];
	end

	a_wr_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_wr |=> out_valid_q)
		else $error("draw write did not present a result");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LAST_IDX)
		else $error("fill counter beyond table");

	a_fill_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill && st.fill_last) |=> (last_q == 32'd1))
		else $error("last output not set after table fill");

endmodule

`default_nettype wire

// File: rtl/slg_ctrl.sv
`default_nettype none

module slg_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire                      restart,
	input  wire  slg_pkg::slg_status_t st,
	output slg_pkg::slg_cmd_t        cmd
);
	import slg_pkg::*;

	slg_state_t state_q;
	slg_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_nxt = restart ? S_LOAD : S_IDX;
			end
			S_LOAD: state_nxt = S_FILL;
			S_FILL: begin
				if (st.fill_last)
					state_nxt = S_IDX;
			end
			S_IDX: state_nxt = S_RD;
			S_RD:  state_nxt = S_WR;
			S_WR: begin
				if (st.out_free)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_LOAD: cmd.ld_seed = 1'b1;
			S_FILL: cmd.fill = 1'b1;
			S_IDX:  cmd.draw_idx = 1'b1;
			S_RD:   cmd.draw_rd = 1'b1;
			// hold the result until the output register has room
			S_WR:   cmd.draw_wr = st.out_free;
			default: ;
		endcase
	end

	a_restart_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && restart) |=> (state_q == S_LOAD))
		else $error("restart transaction did not load seed");

	a_draw_only: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !restart) |=> (state_q == S_IDX))
		else $error("draw transaction did not start a draw");

	a_wr_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_wr |-> st.out_free)
		else $error("result written while output register busy");

endmodule

`default_nettype wire

// File: rtl/shuffled_lcg_uniform_generator_top.sv
// Shuffled multiplicative congruential generator, one 32-bit uniform word per transaction.
// Input channel: in_valid / in_stall with payload restart. A transaction with restart high
// reloads the shuffle table from start_seed (forced odd) before drawing; restart low only draws.
// Output channel: out_valid / out_stall with random_fraction, an unsigned 0.32 fraction.
// Config channel: cfg_valid / cfg_ready (always ready) writes start_seed; write it only while
// no transaction is in flight. start_seed resets to 1.
// Sequence: a draw steps the control sequencer through index multiply, table read and table
// write-back, then returns to idle to take the next transaction. A restart first loads the
// seed and fills the table, one table entry written per cycle through the single table write
// port. The result appears on out_valid the cycle after the write-back.
// The output register holds one result; the next transaction is accepted while it waits, and
// its draw then pauses at write-back until the held result is taken (out_stall low).
// Reset: generator and last output clear to zero and all table entries read as zero until
// written, so draws before the first restart return zero.
`default_nettype none

module shuffled_lcg_uniform_generator_top #(
	parameter int unsigned TABLE_SIZE = 97
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         restart,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] random_fraction,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [31:0] start_seed
);
	import slg_pkg::*;

	slg_cmd_t    cmd;
	slg_status_t st;

	assign cfg_ready = 1'b1;

	slg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.st       (st),
		.cmd      (cmd)
	);

	slg_datapath #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (start_seed),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (random_fraction)
	);

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import slg_pkg::*;

	localparam int unsigned TABLE_SIZE    = 97;
	localparam logic [WORD_W-1:0] MULTIPLIER = 32'd1664525;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned CHUNK_ITEMS   = 100;
	localparam int unsigned MAX_REPORTS   = 10;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              restart;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] random_fraction;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [WORD_W-1:0] start_seed;

	// shadow of the generator state
	logic [WORD_W-1:0] seed_shadow;
	logic [WORD_W-1:0] lcg_word;
	logic [WORD_W-1:0] prev_fraction;
	logic [WORD_W-1:0] shuffle_shadow [TABLE_SIZE];

	logic [WORD_W-1:0] fraction_queue [$];
	logic [WORD_W-1:0] want_fraction;
	int                err_count     = 0;
	int                cycle_count   = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;

	shuffled_lcg_uniform_generator_top #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.random_fraction(random_fraction),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.start_seed     (start_seed)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	function automatic logic [WORD_W-1:0] next_fraction(input logic do_restart);
		logic [WORD_W-1:0] word;
		logic [63:0]       scaled;
		int unsigned       slot;
		logic [WORD_W-1:0] drawn;
		if (do_restart) begin
			// even seeds (zero included) are bumped to the next odd value
			word = seed_shadow | 32'd1;
			for (int k = 0; k < TABLE_SIZE; k++) begin
				word = word * MULTIPLIER;
				shuffle_shadow[k] = word;
			end
			lcg_word      = word;
			prev_fraction = 32'd1;
		end
		scaled = 64'(TABLE_SIZE) * 64'(prev_fraction);
		slot   = scaled[63:32];
		if (slot >= TABLE_SIZE)
			slot = TABLE_SIZE - 1;
		drawn               = shuffle_shadow[slot];
		prev_fraction       = drawn;
		lcg_word            = lcg_word * MULTIPLIER;
		shuffle_shadow[slot] = lcg_word;
		return drawn;
	endfunction

	function automatic logic [WORD_W-1:0] pick_seed();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'hFFFF_FFFE;
			default: return $urandom;
		endcase
	endfunction

	task automatic log_mismatch(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t %s: expected %08h got %08h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (fraction_queue.size() == 0) begin
				log_mismatch("unexpected transaction", '0, random_fraction);
			end else begin
				want_fraction = fraction_queue.pop_front();
				if (want_fraction !== random_fraction)
					log_mismatch("random_fraction mismatch", want_fraction, random_fraction);
			end
		end
	end

	task automatic send_item(input logic do_restart);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			restart  <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= do_restart;
		do
			@(posedge clk);
		while (in_stall);
		fraction_queue.push_back(next_fraction(do_restart));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (fraction_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] seed);
		cfg_valid  <= 1'b1;
		start_seed <= seed;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid   <= 1'b0;
		seed_shadow  = seed;
	endtask

	// table is all zero until the first restart, so every draw gives zero
	task automatic test_draws_from_reset();
		repeat (3) send_item(1'b0);
		wait_idle();
	endtask

	task automatic test_reset_seed();
		send_item(1'b1);
		repeat (2) send_item(1'b0);
		wait_idle();
	endtask

	task automatic test_seed_extremes();
		logic [WORD_W-1:0] seeds [6];
		seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'h8000_0000, 32'h0000_0002, 32'h7FFF_FFFF};
		foreach (seeds[i]) begin
			write_seed(seeds[i]);
			send_item(1'b1);
			send_item(1'b0);
			wait_idle();
		end
	endtask

	task automatic test_restart_runs();
		repeat (2) send_item(1'b1);
		send_item(1'b0);
		wait_idle();
	endtask

	task automatic test_random_phase(input int sender_pct, input int receiver_pct,
			input int n_items);
		int sent;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		sent = 0;
		while (sent < n_items) begin
			wait_idle();
			write_seed(pick_seed());
			// mostly restart after a new seed, sometimes keep the running stream
			send_item($urandom_range(0, 3) != 0);
			sent++;
			for (int k = 1; k < CHUNK_ITEMS && sent < n_items; k++) begin
				send_item($urandom_range(0, 24) == 0);
				sent++;
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		restart    <= 1'b0;
		cfg_valid  <= 1'b0;
		start_seed <= '0;
		seed_shadow   = 32'd1;
		lcg_word      = '0;
		prev_fraction = '0;
		foreach (shuffle_shadow[i])
			shuffle_shadow[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_draws_from_reset();
		test_reset_seed();
		test_seed_extremes();
		test_restart_runs();
		test_random_phase(36, 48, 300);
		test_random_phase(48, 36, 300);
		test_random_phase(0, 0, 300);

		if (err_count == 0 && fraction_queue.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
